// ===== design/plh_pkg.sv =====
// ----------------------------------------------------------------------------
// plh_pkg: packet length histogram shared definitions
// Field widths, item kind codes and edge register reset values.
// ----------------------------------------------------------------------------
package plh_pkg;

   localparam int LENGTH_FIELD_BITS = 16;
   localparam int BIN_FIELD_BITS    = 3;
   localparam int COUNT_FIELD_BITS  = 32;
   localparam int EDGE_BITS         = 16;
   localparam int NUM_EDGE_REGS     = 7;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 16;

   typedef enum logic {
      KIND_RECORD = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   typedef logic [EDGE_BITS-1:0] edge_type;

   localparam edge_type EDGE_RESET [NUM_EDGE_REGS] = '{
      16'd64, 16'd128, 16'd256, 16'd512, 16'd1024, 16'd1519, 16'd2048
   };

endpackage

// ===== design/plh_if.sv =====
// ----------------------------------------------------------------------------
// plh_if: packet length histogram channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface plh_req_if
   import plh_pkg::*;
();
   logic                         valid;
   logic                         ready;
   kind_type                     kind;
   logic [LENGTH_FIELD_BITS-1:0] packet_length;
   logic [BIN_FIELD_BITS-1:0]    read_bin;

   modport source (output valid, kind, packet_length, read_bin, input ready);
   modport sink   (input valid, kind, packet_length, read_bin, output ready);
endinterface

interface plh_rsp_if
   import plh_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic [BIN_FIELD_BITS-1:0]   bin_index;
   logic [COUNT_FIELD_BITS-1:0] bin_count;
   logic [LENGTH_FIELD_BITS-1:0] bin_min;
   logic [LENGTH_FIELD_BITS-1:0] bin_max;
   logic                        bin_empty;
   logic [COUNT_FIELD_BITS-1:0] total_count;

   modport source (output valid, bin_index, bin_count, bin_min, bin_max, bin_empty,
                   total_count, input ready);
   modport sink   (input valid, bin_index, bin_count, bin_min, bin_max, bin_empty,
                   total_count, output ready);
endinterface

interface plh_csr_if
   import plh_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/packet_length_histogram.sv =====
// ----------------------------------------------------------------------------
// packet_length_histogram: per-bin packet length statistics
// Bins packet lengths against programmable edges, keeps saturating counts,
// per-bin min/max and a total; read items report one bin.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake     payload
//  req_bus   in   valid/ready   kind, packet_length, read_bin
//  rsp_bus   out  valid/ready   bin_index, bin_count, bin_min, bin_max,
//                               bin_empty, total_count
//  csr_bus   in   valid/ready   index (edge 1..7 at 0..6), data
//
//  One item per cycle while rsp_bus is ready; an accepted item passes stage A
//  and then the response register before rsp valid rises.
//  Stage A registers the item with its bin (parallel edge compares); stage B
//  does the bin read-modify-write and loads the response register.
//  Synchronous active-high reset clears all statistics and loads default edges.
//  A stalled response holds stage A; req_bus.ready drops only when both are full.
//  csr_bus is always ready; write edges only while the block is idle.
//
module packet_length_histogram
   import plh_pkg::*;
#(
   parameter int NUM_BINS    = 8,
   parameter int LENGTH_BITS = 16,
   parameter int COUNT_BITS  = 32
) (
   input  logic      clock,
   input  logic      reset,
   plh_req_if.sink   req_bus,
   plh_rsp_if.source rsp_bus,
   plh_csr_if.sink   csr_bus
);

   localparam int BIN_BITS  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   // edges actually used for binning
   localparam int NUM_EDGES = (NUM_BINS - 1 < NUM_EDGE_REGS) ? NUM_BINS - 1 : NUM_EDGE_REGS;
   // compare width covering both edge and length
   localparam int CMP_BITS  = (LENGTH_BITS > EDGE_BITS) ? LENGTH_BITS : EDGE_BITS;

   // ---------------- edge registers ----------------
   edge_type edge_ff [NUM_EDGE_REGS];

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_EDGE_REGS; i++) edge_ff[i] <= EDGE_RESET[i];
      end else if (csr_bus.valid &&
                   csr_bus.index < CSR_INDEX_BITS'(NUM_EDGE_REGS)) begin
         edge_ff[csr_bus.index] <= csr_bus.data;
      end
   end

   // ---------------- statistics state ----------------
   logic [COUNT_BITS-1:0]  cnt_ff [NUM_BINS];
   logic [LENGTH_BITS-1:0] min_ff [NUM_BINS];
   logic [LENGTH_BITS-1:0] max_ff [NUM_BINS];
   logic [COUNT_BITS-1:0]  total_ff;

   // ---------------- stage A: item register ----------------
   logic                   a_valid_ff, a_valid_in;
   kind_type               a_kind_ff;
   logic [LENGTH_BITS-1:0] a_len_ff;
   logic [BIN_BITS-1:0]    a_bin_ff;     // array index
   logic [BIN_FIELD_BITS-1:0] a_idx_ff;  // reported bin number
   logic                   a_present_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   req_take;
   logic                   advance;

   logic [LENGTH_BITS-1:0] req_len;
   logic [BIN_BITS-1:0]    rec_bin;
   logic                   rec_found;

   assign advance       = a_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !a_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign req_len       = LENGTH_BITS'(req_bus.packet_length);

   // first edge above the length picks the bin; none above means bin NUM_EDGES
   always_comb begin
      rec_bin   = BIN_BITS'(NUM_EDGES);
      rec_found = 1'b0;
      for (int i = 0; i < NUM_EDGES; i++) begin
         if (!rec_found && (CMP_BITS'(edge_ff[i]) > CMP_BITS'(req_len))) begin
            rec_bin   = BIN_BITS'(i);
            rec_found = 1'b1;
         end
      end
   end

   always_comb begin
      if (req_take)      a_valid_in = 1'b1;
      else if (advance)  a_valid_in = 1'b0;
      else               a_valid_in = a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else       a_valid_ff <= a_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_kind_ff <= req_bus.kind;
         a_len_ff  <= req_len;
         if (req_bus.kind == KIND_RECORD) begin
            a_bin_ff     <= rec_bin;
            a_idx_ff     <= BIN_FIELD_BITS'(rec_bin);
            a_present_ff <= 1'b1;
         end else begin
            a_bin_ff     <= BIN_BITS'(req_bus.read_bin);
            a_idx_ff     <= req_bus.read_bin;
            a_present_ff <= (32'(req_bus.read_bin) < NUM_BINS);
         end
      end
   end

   // ---------------- stage B: update and respond ----------------
   logic [COUNT_BITS-1:0]  cur_cnt, new_cnt, new_total;
   logic [LENGTH_BITS-1:0] cur_min, cur_max, new_min, new_max;
   logic [COUNT_BITS-1:0]  out_cnt;
   logic [LENGTH_BITS-1:0] out_min, out_max;
   logic [COUNT_BITS-1:0]  out_total;
   logic                   out_empty;
   logic                   do_record;

   always_comb begin
      cur_cnt = '0;
      cur_min = '1;
      cur_max = '0;
      if (a_present_ff) begin
         cur_cnt = cnt_ff[a_bin_ff];
         cur_min = min_ff[a_bin_ff];
         cur_max = max_ff[a_bin_ff];
      end
      new_cnt   = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
      new_total = (total_ff == '1) ? total_ff : total_ff + 1'b1;
      new_min   = (a_len_ff < cur_min) ? a_len_ff : cur_min;
      new_max   = (a_len_ff > cur_max) ? a_len_ff : cur_max;

      if (a_kind_ff == KIND_RECORD) begin
         out_cnt   = new_cnt;
         out_min   = new_min;
         out_max   = new_max;
         out_total = new_total;
      end else begin
         out_cnt   = cur_cnt;
         out_min   = cur_min;
         out_max   = cur_max;
         out_total = total_ff;
      end
      // an empty bin reports zero min and max
      out_empty = (out_cnt == '0);
      if (out_empty) begin
         out_min = '0;
         out_max = '0;
      end
   end

   assign do_record = advance && (a_kind_ff == KIND_RECORD);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            cnt_ff[i] <= '0;
            min_ff[i] <= '1;
            max_ff[i] <= '0;
         end
         total_ff <= '0;
      end else if (do_record) begin
         cnt_ff[a_bin_ff] <= new_cnt;
         min_ff[a_bin_ff] <= new_min;
         max_ff[a_bin_ff] <= new_max;
         total_ff         <= new_total;
      end
   end

   // ---------------- response register ----------------
   logic [BIN_FIELD_BITS-1:0]    rsp_index_ff;
   logic [COUNT_FIELD_BITS-1:0]  rsp_count_ff;
   logic [LENGTH_FIELD_BITS-1:0] rsp_min_ff;
   logic [LENGTH_FIELD_BITS-1:0] rsp_max_ff;
   logic                         rsp_empty_ff;
   logic [COUNT_FIELD_BITS-1:0]  rsp_total_ff;

   always_comb begin
      if (advance)            rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
      else                    rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_index_ff <= a_idx_ff;
         rsp_count_ff <= COUNT_FIELD_BITS'(out_cnt);
         rsp_min_ff   <= LENGTH_FIELD_BITS'(out_min);
         rsp_max_ff   <= LENGTH_FIELD_BITS'(out_max);
         rsp_empty_ff <= out_empty;
         rsp_total_ff <= COUNT_FIELD_BITS'(out_total);
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.bin_index   = rsp_index_ff;
   assign rsp_bus.bin_count   = rsp_count_ff;
   assign rsp_bus.bin_min     = rsp_min_ff;
   assign rsp_bus.bin_max     = rsp_max_ff;
   assign rsp_bus.bin_empty   = rsp_empty_ff;
   assign rsp_bus.total_count = rsp_total_ff;

endmodule

// ===== design/plh_checker.sv =====
// ----------------------------------------------------------------------------
// plh_checker: packet length histogram port checks
// Response handshake and reported statistics consistency.
// ----------------------------------------------------------------------------
module plh_checker
   import plh_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [COUNT_FIELD_BITS-1:0]  rsp_bin_count,
   input logic [LENGTH_FIELD_BITS-1:0] rsp_bin_min,
   input logic [LENGTH_FIELD_BITS-1:0] rsp_bin_max,
   input logic                         rsp_bin_empty,
   input logic [COUNT_FIELD_BITS-1:0]  rsp_total_count
);

   // stalled response keeps its item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_count) &&
         $stable(rsp_total_count) && $stable(rsp_bin_min))
      else $error("response changed while stalled");

   // nothing is offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // empty bin reports zero statistics
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bin_empty |->
         rsp_bin_count == '0 && rsp_bin_min == '0 && rsp_bin_max == '0)
      else $error("empty bin with nonzero statistics");

   // populated bin has ordered min and max
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bin_empty |-> rsp_bin_min <= rsp_bin_max)
      else $error("bin minimum above maximum");

endmodule

bind packet_length_histogram plh_checker u_plh_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_bin_count   (rsp_bus.bin_count),
   .rsp_bin_min     (rsp_bus.bin_min),
   .rsp_bin_max     (rsp_bus.bin_max),
   .rsp_bin_empty   (rsp_bus.bin_empty),
   .rsp_total_count (rsp_bus.total_count)
);
